// ----- hdl/xoroshiro64_range_random_defines.svh -----
// ----------------------------------------------------------------------------
// xoroshiro64_range_random_defines.svh
// assertion macros used by the range random generator
// ----------------------------------------------------------------------------
`ifndef XOROSHIRO64_RANGE_RANDOM_DEFINES_SVH
`define XOROSHIRO64_RANGE_RANDOM_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define XRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define XRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/xrr_pkg.sv -----
// ----------------------------------------------------------------------------
// xrr_pkg
// types, constants and helper functions of the range random generator
// ----------------------------------------------------------------------------
package xrr_pkg;

  // request actions
  typedef enum logic [1:0] {
    ACT_FRACTION = 2'd0,
    ACT_UPPER    = 2'd1,
    ACT_RANGE    = 2'd2,
    ACT_RESEED   = 2'd3
  } action_t;

  // splitmix32 constants
  localparam logic [31:0] SPLIT_INC = 32'h9e37_79b9;
  localparam logic [31:0] MIX_MUL1  = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_MUL2  = 32'hc2b2_ae35;

  // xoroshiro64** output scrambler multiplier
  localparam logic [31:0] SCRAMBLE_MUL = 32'h9E37_79BB;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one draw waiting for the back end
  typedef struct packed {
    action_t            action;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic [31:0]        word0;
  } draw_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int k);
    rotl32 = (v << k) | (v >> (32 - k));
  endfunction

  // full splitmix32 mix of an already incremented accumulator
  function automatic logic [31:0] mix_word(input logic [31:0] acc);
    logic [31:0] z;
    z = (acc ^ (acc >> 16)) * MIX_MUL1;
    z = (z ^ (z >> 13)) * MIX_MUL2;
    mix_word = z ^ (z >> 16);
  endfunction

  // generator words after reset, as a reseed with seed zero leaves them
  localparam logic [31:0] SPLIT_INC2  = SPLIT_INC + SPLIT_INC;
  localparam logic [31:0] GEN_RESET0  = mix_word(SPLIT_INC);
  localparam logic [31:0] GEN_RESET1  = mix_word(SPLIT_INC2);

endpackage

// ----- hdl/xrr_req_if.sv -----
// ----------------------------------------------------------------------------
// xrr_req_if
// request channel: action with bounds and seed
// ----------------------------------------------------------------------------
interface xrr_req_if;
  import xrr_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] lower;
  logic signed [31:0] upper;
  logic [31:0]        seed;

  modport source (output valid, output action, output lower, output upper,
                  output seed, input ready);
  modport sink   (input valid, input action, input lower, input upper,
                  input seed, output ready);
endinterface

// ----- hdl/xrr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// xrr_rsp_if
// result channel: raw word, scaled value and status
// ----------------------------------------------------------------------------
interface xrr_rsp_if;
  import xrr_pkg::*;

  logic               valid;
  logic               ready;
  logic [31:0]        fraction;
  logic signed [31:0] value;
  logic               status;

  modport source (output valid, output fraction, output value, output status,
                  input ready);
  modport sink   (input valid, input fraction, input value, input status,
                  output ready);
endinterface

// ----- hdl/xrr_front.sv -----
// ----------------------------------------------------------------------------
// xrr_front
// holds the generator words, advances them per draw, runs splitmix reseed
// ----------------------------------------------------------------------------
module xrr_front (
  input  logic           clk,
  input  logic           rst,
  xrr_req_if.sink        req,
  output logic           push_valid,
  input  logic           push_ready,
  output xrr_pkg::draw_t push_data
);
  import xrr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_STORE
  } state_t;

  state_t      state;
  logic [31:0] w0;
  logic [31:0] w1;
  logic [31:0] acc;
  logic [31:0] mix;
  logic        word_sel;

  logic        accept;
  logic        is_reseed;
  logic [31:0] b_mix;
  logic [31:0] fin;

  // take requests only when idle and the queue has room
  assign req.ready  = (state == ST_IDLE) && push_ready;
  assign accept     = req.valid && req.ready;
  assign is_reseed  = (action_t'(req.action) == ACT_RESEED);

  // each draw carries the pre-advance first word to the back end
  assign push_valid       = accept && !is_reseed;
  assign push_data.action = action_t'(req.action);
  assign push_data.lower  = req.lower;
  assign push_data.upper  = req.upper;
  assign push_data.word0  = w0;

  assign b_mix = w1 ^ w0;
  assign fin   = mix ^ (mix >> 16);

  // generator state and reseed sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      w0       <= GEN_RESET0;
      w1       <= GEN_RESET1;
      word_sel <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_reseed) begin
              acc      <= req.seed + SPLIT_INC;
              word_sel <= 1'b0;
              state    <= ST_MUL1;
            end else begin
              w0 <= rotl32(w0, 26) ^ b_mix ^ (b_mix << 9);
              w1 <= rotl32(b_mix, 13);
            end
          end
        end
        ST_MUL1: begin
          mix   <= (acc ^ (acc >> 16)) * MIX_MUL1;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          mix   <= (mix ^ (mix >> 13)) * MIX_MUL2;
          state <= ST_STORE;
        end
        ST_STORE: begin
          if (!word_sel) begin
            w0       <= fin;
            acc      <= acc + SPLIT_INC;
            word_sel <= 1'b1;
            state    <= ST_MUL1;
          end else begin
            w1    <= fin;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/xrr_queue.sv -----
// ----------------------------------------------------------------------------
// xrr_queue
// short fifo of pending draws between front and back
// ----------------------------------------------------------------------------
module xrr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  xrr_pkg::draw_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output xrr_pkg::draw_t pop_data
);
  import xrr_pkg::*;

  draw_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/xrr_back.sv -----
// ----------------------------------------------------------------------------
// xrr_back
// scrambles the generator word and scales it into the requested interval
// ----------------------------------------------------------------------------
module xrr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  xrr_pkg::draw_t pop_data,
  xrr_rsp_if.source      rsp
);
  import xrr_pkg::*;

  // stage 1: scrambler multiply, span, offset, empty check
  logic        s1_valid;
  logic [31:0] s1_mul;
  logic [32:0] s1_span;
  logic [31:0] s1_offset;
  logic        s1_status;
  // stage 2: rotate and times five
  logic        s2_valid;
  logic [31:0] s2_word;
  logic [32:0] s2_span;
  logic [31:0] s2_offset;
  logic        s2_status;
  // stage 3: scaling product
  logic        s3_valid;
  logic [31:0] s3_word;
  logic [63:0] s3_prod;
  logic [31:0] s3_offset;
  logic        s3_status;
  // output register
  logic        o_valid;
  logic [31:0] o_fraction;
  logic [31:0] o_value;
  logic        o_status;

  logic        adv;
  logic [32:0] span_next;
  logic [31:0] offset_next;
  logic        status_next;
  logic [32:0] range_span;
  logic [31:0] rot_word;

  // whole pipe moves unless the output is held
  assign adv       = !o_valid || rsp.ready;
  assign pop_ready = adv;

  assign range_span = {pop_data.upper[31], pop_data.upper}
                    - {pop_data.lower[31], pop_data.lower} + 33'd1;

  // classify the draw; span and offset are zero where no value is made
  always_comb begin
    span_next   = '0;
    offset_next = '0;
    status_next = 1'b0;
    unique case (pop_data.action) inside
      ACT_UPPER: begin
        if (pop_data.upper[31] || (pop_data.upper == '0)) begin
          status_next = 1'b1;
        end else begin
          span_next   = {1'b0, pop_data.upper};
          offset_next = 32'd1;
        end
      end
      ACT_RANGE: begin
        if (pop_data.upper < pop_data.lower) begin
          status_next = 1'b1;
        end else begin
          span_next   = range_span;
          offset_next = pop_data.lower;
        end
      end
      ACT_FRACTION, ACT_RESEED: begin
        span_next = '0;
      end
      default: span_next = '0;
    endcase
  end

  assign rot_word = rotl32(s1_mul, 5);

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= pop_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      o_valid  <= s3_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mul     <= pop_data.word0 * SCRAMBLE_MUL;
      s1_span    <= span_next;
      s1_offset  <= offset_next;
      s1_status  <= status_next;

      s2_word    <= rot_word + {rot_word[29:0], 2'b00};
      s2_span    <= s1_span;
      s2_offset  <= s1_offset;
      s2_status  <= s1_status;

      s3_word    <= s2_word;
      s3_prod    <= {32'd0, s2_word} * {31'd0, s2_span};
      s3_offset  <= s2_offset;
      s3_status  <= s2_status;

      o_fraction <= s3_word;
      o_value    <= s3_prod[63:32] + s3_offset;
      o_status   <= s3_status;
    end
  end

  assign rsp.valid    = o_valid;
  assign rsp.fraction = o_fraction;
  assign rsp.value    = o_value;
  assign rsp.status   = o_status;

endmodule

// ----- hdl/xoroshiro64_range_random.sv -----
// ----------------------------------------------------------------------------
// xoroshiro64_range_random
// xoroshiro64** generator with fraction, 1..upper and lower..upper draws
// ----------------------------------------------------------------------------
// Usage:
//   req carries action, lower, upper and seed under valid/ready; rsp returns
//   fraction, value and status under valid/ready. A transfer happens when
//   valid and ready are both high at a rising edge.
//   Draw actions (fraction, upper, range) each give one result, in order.
//   A reseed gives no result; it runs the splitmix32 sequencer (two words,
//   three steps each) during which req.ready stays low.
//   Draws are taken one per cycle while the queue has room and no reseed
//   runs. A draw transfer is registered in the queue, which feeds the
//   scrambler multiply register; then come the rotate and times-five step,
//   the 32x33 scaling multiply and the output register.
//   An empty interval returns status 1 and value 0; the raw word still comes
//   out in fraction and the generator still advances.
//   Reset (rst, synchronous) loads the words a reseed with seed zero gives
//   and empties queue and pipeline; no clearing pass follows.
//   When rsp is stalled the whole back pipeline holds, the queue fills, and
//   req.ready drops once the queue is full.
// ----------------------------------------------------------------------------
`include "xoroshiro64_range_random_defines.svh"

module xoroshiro64_range_random (
  input  logic      clk,
  input  logic      rst,
  xrr_req_if.sink   req,
  xrr_rsp_if.source rsp
);
  import xrr_pkg::*;

  logic  push_valid;
  logic  push_ready;
  draw_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  draw_t pop_data;

  // front: generator state and reseed
  xrr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // queue of pending draws
  xrr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: scramble and scale
  xrr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .rsp       (rsp)
  );

  // a reseed transfer blocks the next request
  `XRR_ASSERT_NEXT(a_reseed_busy, req.valid && req.ready && (req.action == ACT_RESEED), !req.ready, "request taken during reseed")
  // every draw transfer lands in the queue
  `XRR_ASSERT_NOW(a_draw_queued, req.valid && req.ready && (req.action != ACT_RESEED), push_valid && push_ready, "draw not queued")
  // empty interval results carry a zero value
  `XRR_ASSERT_NOW(a_empty_zero, rsp.valid && rsp.status, rsp.value == '0, "nonzero value with empty interval")

endmodule
